// ----- design/rotating_element_store_defines.svh -----
`ifndef ROTATING_ELEMENT_STORE_DEFINES_SVH
`define ROTATING_ELEMENT_STORE_DEFINES_SVH

// same-cycle check, quiet while in reset
`define RES_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("rotating element store check failed");

// next-cycle check, quiet while in reset
`define RES_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("rotating element store check failed");

`endif

// ----- design/res_pkg.sv -----
package res_pkg;

  localparam int CAPACITY_DEF = 16;

  localparam int FUNC_W   = 3;
  localparam int VALUE_W  = 32;
  localparam int INDEX_W  = 4;
  localparam int AMT_W    = 8;
  localparam int STATUS_W = 2;
  localparam int K_W      = $clog2(AMT_W);

  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH = 3'd0,
    FN_READ = 3'd1,
    FN_ROR  = 3'd2,
    FN_ROL  = 3'd3,
    FN_SHR  = 3'd4,
    FN_SHL  = 3'd5
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_BAD_INDEX = 2'd1,
    STAT_FULL      = 2'd2
  } status_t;

  // control broadcast to every cell of the chain
  typedef struct packed {
    logic load;       // write the push word into the cell at the count
    logic step;       // move the live window by one position
    logic left;       // direction of the step
    logic zero_fill;  // last live cell takes zero instead of the head
  } cell_ctrl_t;

endpackage

// ----- design/res_cell.sv -----
module res_cell #(
  parameter int POS   = 0,
  parameter int CNT_W = 5
) (
  input  logic                         clk,
  input  res_pkg::cell_ctrl_t          ctl,
  input  logic [CNT_W-1:0]             count,
  input  logic [res_pkg::VALUE_W-1:0]  push_value,
  input  logic [res_pkg::VALUE_W-1:0]  from_left,
  input  logic [res_pkg::VALUE_W-1:0]  from_right,
  input  logic [res_pkg::VALUE_W-1:0]  head,
  output logic [res_pkg::VALUE_W-1:0]  elem
);

  logic                        live;
  logic                        is_last;
  logic                        is_slot;
  logic [res_pkg::VALUE_W-1:0] elem_next;

  assign live    = CNT_W'(POS) < count;
  assign is_last = count == CNT_W'(POS + 1);
  assign is_slot = count == CNT_W'(POS);

  always_comb begin
    if (!ctl.left) begin
      elem_next = from_left;
    end else if (is_last) begin
      elem_next = ctl.zero_fill ? '0 : head;
    end else begin
      elem_next = from_right;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load && is_slot) begin
      elem <= push_value;
    end else if (ctl.step && live) begin
      elem <= elem_next;
    end
  end

endmodule

// ----- design/res_ctrl.sv -----
`include "rotating_element_store_defines.svh"

module res_ctrl #(
  parameter int CAPACITY = res_pkg::CAPACITY_DEF,
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_valid,
  output logic                          s_ready,
  input  logic [res_pkg::FUNC_W-1:0]    s_func,
  input  logic [res_pkg::VALUE_W-1:0]   s_value,
  input  logic [res_pkg::INDEX_W-1:0]   s_index,
  input  logic [res_pkg::AMT_W-1:0]     s_amount,
  output logic                          m_valid,
  input  logic                          m_ready,
  output logic [res_pkg::STATUS_W-1:0]  m_status,
  output logic [res_pkg::VALUE_W-1:0]   m_read_value,
  output logic [CNT_W-1:0]              m_count,
  output logic [res_pkg::INDEX_W-1:0]   rd_index,
  input  logic [res_pkg::VALUE_W-1:0]   rd_data,
  output res_pkg::cell_ctrl_t           cell_ctl,
  output logic [CNT_W-1:0]              count,
  output logic [res_pkg::VALUE_W-1:0]   push_value
);

  localparam int SUM_W = CNT_W + res_pkg::AMT_W;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_EXEC   = 5'b00010,
    S_REDUCE = 5'b00100,
    S_MOVE   = 5'b01000,
    S_RESULT = 5'b10000
  } state_t;

  state_t                       state;
  logic [res_pkg::FUNC_W-1:0]   op_func;
  logic [res_pkg::VALUE_W-1:0]  op_value;
  logic [res_pkg::INDEX_W-1:0]  op_index;
  logic [res_pkg::AMT_W-1:0]    op_amount;
  logic [res_pkg::AMT_W-1:0]    rem;
  logic [res_pkg::K_W-1:0]      k;
  logic [CNT_W-1:0]             steps;
  logic                         move_left;
  logic                         move_zero;
  logic [res_pkg::STATUS_W-1:0] res_status;
  logic [res_pkg::VALUE_W-1:0]  res_rd;

  logic [SUM_W-1:0]             n_shift;
  logic [SUM_W-1:0]             rem_ext;
  logic [res_pkg::AMT_W-1:0]    rem_next;
  logic [CNT_W-1:0]             shift_steps;
  logic                         full;
  logic                         bad_index;
  logic                         out_load;

  // one restoring step of amount modulo count
  assign n_shift  = SUM_W'(count) << k;
  assign rem_ext  = SUM_W'(rem);
  assign rem_next = (rem_ext >= n_shift) ? res_pkg::AMT_W'(rem_ext - n_shift) : rem;

  assign shift_steps = (SUM_W'(op_amount) < SUM_W'(count)) ? CNT_W'(op_amount) : count;
  assign full        = count == CNT_W'(CAPACITY);
  assign bad_index   = SUM_W'(op_index) >= SUM_W'(count);

  // result register takes a new word once the old one has gone
  assign out_load = (state == S_RESULT) && (!m_valid || m_ready);

  assign s_ready    = state == S_IDLE;
  assign rd_index   = op_index;
  assign push_value = op_value;

  always_comb begin
    cell_ctl.load      = (state == S_EXEC) && (op_func == res_pkg::FN_PUSH) && !full;
    cell_ctl.step      = state == S_MOVE;
    cell_ctl.left      = move_left;
    cell_ctl.zero_fill = move_zero;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      m_valid <= 1'b0;
    end else begin
      if (out_load) begin
        m_valid <= 1'b1;
      end else if (m_ready) begin
        m_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_valid) begin
            op_func   <= s_func;
            op_value  <= s_value;
            op_index  <= s_index;
            op_amount <= s_amount;
            state     <= S_EXEC;
          end
        end
        S_EXEC: begin
          res_status <= res_pkg::STAT_OK;
          res_rd     <= '0;
          state      <= S_RESULT;
          unique case (op_func)
            res_pkg::FN_PUSH: begin
              if (full) begin
                res_status <= res_pkg::STAT_FULL;
              end else begin
                count <= count + CNT_W'(1);
              end
            end
            res_pkg::FN_READ: begin
              if (bad_index) begin
                res_status <= res_pkg::STAT_BAD_INDEX;
              end else begin
                res_rd <= rd_data;
              end
            end
            res_pkg::FN_ROR, res_pkg::FN_ROL: begin
              if (count != '0 && op_amount != '0) begin
                rem   <= op_amount;
                k     <= res_pkg::K_W'(res_pkg::AMT_W - 1);
                state <= S_REDUCE;
              end
            end
            res_pkg::FN_SHR, res_pkg::FN_SHL: begin
              if (count != '0 && op_amount != '0) begin
                steps     <= shift_steps;
                move_left <= op_func == res_pkg::FN_SHL;
                move_zero <= 1'b1;
                state     <= S_MOVE;
              end
            end
            default: begin
            end
          endcase
        end
        S_REDUCE: begin
          rem <= rem_next;
          k   <= k - res_pkg::K_W'(1);
          if (k == '0) begin
            // right rotation runs as a left one of count minus the remainder
            move_left <= 1'b1;
            move_zero <= 1'b0;
            if (rem_next == '0) begin
              state <= S_RESULT;
            end else begin
              steps <= (op_func == res_pkg::FN_ROL) ? CNT_W'(rem_next)
                                                     : count - CNT_W'(rem_next);
              state <= S_MOVE;
            end
          end
        end
        S_MOVE: begin
          steps <= steps - CNT_W'(1);
          if (steps == CNT_W'(1)) begin
            state <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (out_load) begin
            m_status     <= res_status;
            m_read_value <= res_rd;
            m_count      <= count;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `RES_ASSERT_NOW(a_count_bound, 1'b1, count <= CNT_W'(CAPACITY))
  `RES_ASSERT_NEXT(a_count_held, (state == S_REDUCE) || (state == S_MOVE), count == $past(count))
  `RES_ASSERT_NOW(a_steps_live, state == S_MOVE, (steps != '0) && (count != '0))
  `RES_ASSERT_NEXT(a_push_full, (state == S_EXEC) && (op_func == res_pkg::FN_PUSH) && full, (res_status == res_pkg::STAT_FULL) && (count == $past(count)))

endmodule

// ----- design/rotating_element_store.sv -----
// rotating element store: a row of element cells with a fill count
//
// input words (s_axis) carry one operation each: push, read, rotate right,
// rotate left, shift right or shift left. every input word returns exactly
// one output word (m_axis) with a status, the read data and the count.
//
// an input word is taken only while the store is idle; it then runs the
// execute state and, for a rotate or shift, moves the live elements one
// position per cycle along the cell chain
//   push, read, zero amount, empty store : no moves
//   shift                                 : min(amount, count) moves
//   rotate                                : (amount mod count) moves, after
//                                           the bit-serial remainder unit
//                                           has reduced the amount
// a right rotation is run as a left one, so it takes count minus the
// remainder moves instead
//
// the result sits in an output register; the next input word is taken while
// it waits, and a receiver stall only holds the core once a second result
// is ready. reset clears the count and the handshake state; the element
// cells keep whatever they held and are never read until pushed
module rotating_element_store #(
  parameter  int CAPACITY = res_pkg::CAPACITY_DEF,
  localparam int CNT_W    = $clog2(CAPACITY + 1),
  localparam int IN_W     = ((res_pkg::VALUE_W + res_pkg::INDEX_W + res_pkg::AMT_W + 7) / 8) * 8,
  localparam int OUT_W    = ((res_pkg::VALUE_W + CNT_W + 7) / 8) * 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [IN_W-1:0]               s_axis_tdata,  // value, index, amount
  input  logic [res_pkg::FUNC_W-1:0]    s_axis_tuser,  // func
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [OUT_W-1:0]              m_axis_tdata,  // read_value, count
  output logic [res_pkg::STATUS_W-1:0]  m_axis_tuser   // status
);

  localparam int SUM_W = CNT_W + res_pkg::AMT_W;
  localparam int IX_LO = res_pkg::VALUE_W;
  localparam int AM_LO = IX_LO + res_pkg::INDEX_W;

  // unpacked input word
  logic [res_pkg::VALUE_W-1:0]  in_value;
  logic [res_pkg::INDEX_W-1:0]  in_index;
  logic [res_pkg::AMT_W-1:0]    in_amount;

  // result fields
  logic [res_pkg::VALUE_W-1:0]  out_rd;
  logic [CNT_W-1:0]             out_count;

  // chain control and cell contents
  res_pkg::cell_ctrl_t          cell_ctl;
  logic [CNT_W-1:0]             count;
  logic [res_pkg::VALUE_W-1:0]  push_value;
  logic [res_pkg::INDEX_W-1:0]  rd_index;
  logic [res_pkg::VALUE_W-1:0]  rd_data;
  logic [res_pkg::VALUE_W-1:0]  elem [CAPACITY];

  assign in_value  = s_axis_tdata[IX_LO-1:0];
  assign in_index  = s_axis_tdata[AM_LO-1:IX_LO];
  assign in_amount = s_axis_tdata[AM_LO+res_pkg::AMT_W-1:AM_LO];

  assign m_axis_tdata = OUT_W'({out_count, out_rd});

  res_ctrl #(
    .CAPACITY (CAPACITY),
    .CNT_W    (CNT_W)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .s_valid      (s_axis_tvalid),
    .s_ready      (s_axis_tready),
    .s_func       (s_axis_tuser),
    .s_value      (in_value),
    .s_index      (in_index),
    .s_amount     (in_amount),
    .m_valid      (m_axis_tvalid),
    .m_ready      (m_axis_tready),
    .m_status     (m_axis_tuser),
    .m_read_value (out_rd),
    .m_count      (out_count),
    .rd_index     (rd_index),
    .rd_data      (rd_data),
    .cell_ctl     (cell_ctl),
    .count        (count),
    .push_value   (push_value)
  );

  // read port: pick the cell at the requested index, bounds are checked in
  // the controller against the count
  always_comb begin
    rd_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (SUM_W'(rd_index) == SUM_W'(i)) begin
        rd_data = elem[i];
      end
    end
  end

  // chain of cells; the ends see zero, and the head is broadcast so that a
  // left rotation can wrap it into the last live cell
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [res_pkg::VALUE_W-1:0] left_in;
    logic [res_pkg::VALUE_W-1:0] right_in;

    if (g == 0) begin : g_first
      assign left_in = '0;
    end else begin : g_mid_l
      assign left_in = elem[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign right_in = '0;
    end else begin : g_mid_r
      assign right_in = elem[g+1];
    end

    res_cell #(
      .POS   (g),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk        (clk),
      .ctl        (cell_ctl),
      .count      (count),
      .push_value (push_value),
      .from_left  (left_in),
      .from_right (right_in),
      .head       (elem[0]),
      .elem       (elem[g])
    );
  end

endmodule
